### rtl/core/pgdl_pkg.sv
// Shared types and constants of the proximity gain delay line.
// No dependencies; imported by every module of the block.
package pgdl_pkg;

  localparam int DELAY_DEPTH_DEF = 32768;

  // distance = DIST_AT_ZERO - round(raw * DIST_SLOPE / 2^16), Q8.8 cm
  localparam logic signed [15:0] DIST_AT_ZERO = 16'sd15083;
  localparam logic [14:0] DIST_SLOPE = 15'd17066;
  localparam logic [15:0] GAIN_ONE = 16'd32768;

  localparam logic [14:0] DELAY_RST = 15'd4410;
  localparam logic [14:0] TRIG_RST = 15'd10240;
  localparam logic [15:0] GPC_RST = 16'd3277;

  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_AW-1:0] REG_TRIG = 2'd1;
  localparam logic [CFG_AW-1:0] REG_GPC = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [15:0] dry;
    logic [15:0] gain;
    logic [1:0] idx;
  } job_t;

endpackage

### rtl/core/proximity_gain_delay_line_unit.sv
// Proximity gain delay line, top level: config registers, delay reduction, front/back.
// Depends on pgdl_pkg, pgdl_front, pgdl_queue, pgdl_back.
// The back end finishes the read, multiply and write-back of one item before it takes the next.
// Reset: synchronous; a clearing pass then zeroes memory, no input taken.
// A delay write stalls input while the delay is reduced modulo DELAY_DEPTH.
module proximity_gain_delay_line_unit
  import pgdl_pkg::*;
#(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // dry_sample[15:0], sensor_a_raw[31:16], sensor_b_raw[47:32], sensor_c_raw[63:48]
  input  logic [63:0]       in_tdata,
  // sensor_valid[0]
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // wet_sample[15:0], nearest_sensor[17:16], applied_gain[33:18], zero pad[39:34]
  output logic [39:0]       out_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [15:0]       cfg_wdata
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int LW = (AW + 1 > 15) ? AW + 1 : 15;

  logic [LW-1:0] dly_r;
  logic          red_busy_r;
  logic [14:0]   trig_r;
  logic [15:0]   gpc_r;

  logic          en;
  logic          take;
  logic          push;
  job_t          push_job;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  job_t          head;
  logic          clr_busy;
  logic [15:0]   raw [3];
  logic signed [15:0] wet;
  logic [1:0]    near;
  logic [15:0]   gain;

  assign in_tready = en && !clr_busy && !red_busy_r;
  assign take      = in_tvalid && in_tready;
  assign raw[0]    = in_tdata[31:16];
  assign raw[1]    = in_tdata[47:32];
  assign raw[2]    = in_tdata[63:48];
  assign out_tdata = {6'd0, gain, near, wet};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r      <= LW'(DELAY_RST);
      red_busy_r <= 1'b1;
      trig_r     <= TRIG_RST;
      gpc_r      <= GPC_RST;
    end else begin
      if (cfg_we && cfg_addr == REG_DELAY) begin
        dly_r      <= LW'(cfg_wdata[14:0]);
        red_busy_r <= 1'b1;
      end else if (red_busy_r) begin
        if (dly_r >= LW'(DELAY_DEPTH)) begin
          dly_r <= dly_r - LW'(DELAY_DEPTH);
        end else begin
          red_busy_r <= 1'b0;
        end
      end
      if (cfg_we && cfg_addr == REG_TRIG) begin
        trig_r <= cfg_wdata[14:0];
      end
      if (cfg_we && cfg_addr == REG_GPC) begin
        gpc_r <= cfg_wdata;
      end
    end
  end

  pgdl_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .take             (take),
    .dry_sample       (in_tdata[15:0]),
    .sensor_valid     (in_tuser),
    .sensor_raw       (raw),
    .trigger_distance (trig_r),
    .gain_per_cm      (gpc_r),
    .q_full           (q_full),
    .en               (en),
    .push             (push),
    .push_job         (push_job)
  );

  pgdl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  pgdl_back #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .dly            (dly_r[AW-1:0]),
    .clr_busy       (clr_busy),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .wet_sample     (wet),
    .nearest_sensor (near),
    .applied_gain   (gain)
  );

endmodule

### rtl/core/pgdl_front.sv
// Front end: sensor distance conversion, nearest-sensor search and gain.
// Depends on pgdl_pkg. Feeds jobs into pgdl_queue.
module pgdl_front
  import pgdl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic signed [15:0] dry_sample,
  input  logic               sensor_valid,
  input  logic [15:0]        sensor_raw [3],
  input  logic [14:0]        trigger_distance,
  input  logic [15:0]        gain_per_cm,
  input  logic               q_full,
  output logic               en,
  output logic               push,
  output job_t               push_job
);

  logic               a_v_r;
  logic               a_sv_r;
  logic signed [15:0] a_dry_r;
  logic [30:0]        a_prod_r [3];

  logic               b_v_r;
  logic               b_zero_r;
  logic [1:0]         b_idx_r;
  logic [15:0]        b_diff_r;
  logic signed [15:0] b_dry_r;

  logic signed [15:0] held_r [3];
  logic signed [15:0] sel [3];
  logic [14:0]        drop [3];
  logic signed [15:0] near;
  logic [1:0]         near_idx;
  logic signed [16:0] near_x;
  logic signed [16:0] trig_x;
  logic signed [16:0] diff_x;
  logic [31:0]        gprod;
  logic [32:0]        gsum;
  logic [23:0]        graw;
  logic [15:0]        gain;

  assign en = !(b_v_r && q_full);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      drop[i] = 15'(({1'b0, a_prod_r[i]} + 32'd32768) >> 16);
      sel[i]  = a_sv_r ? (DIST_AT_ZERO - $signed({1'b0, drop[i]})) : held_r[i];
    end
    near     = sel[0];
    near_idx = 2'd0;
    if (sel[1] < near) begin
      near     = sel[1];
      near_idx = 2'd1;
    end
    if (sel[2] < near) begin
      near     = sel[2];
      near_idx = 2'd2;
    end
    near_x = {near[15], near};
    trig_x = $signed({2'b00, trigger_distance});
    diff_x = trig_x - near_x;
  end

  always_comb begin
    gprod = b_diff_r * gain_per_cm;
    gsum  = {1'b0, gprod} + 33'd256;
    graw  = gsum[32:9];
    priority if (b_zero_r) begin
      gain = '0;
    end else if (graw > {8'd0, GAIN_ONE}) begin
      gain = GAIN_ONE;
    end else begin
      gain = graw[15:0];
    end
  end

  assign push          = b_v_r && !q_full;
  assign push_job.dry  = b_dry_r;
  assign push_job.gain = gain;
  assign push_job.idx  = b_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= '0;
      end
    end else if (en) begin
      a_v_r <= take;
      b_v_r <= a_v_r;
      if (a_v_r && a_sv_r) begin
        for (int i = 0; i < 3; i++) begin
          held_r[i] <= sel[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sv_r  <= sensor_valid;
      a_dry_r <= dry_sample;
      for (int i = 0; i < 3; i++) begin
        a_prod_r[i] <= sensor_raw[i] * DIST_SLOPE;
      end
      b_dry_r  <= a_dry_r;
      b_idx_r  <= near_idx;
      b_zero_r <= near_x > trig_x;
      b_diff_r <= diff_x[15:0];
    end
  end

endmodule

### rtl/core/pgdl_queue.sv
// Short job queue between front and back ends.
// Depends on pgdl_pkg for job_t and the queue depth.
module pgdl_queue
  import pgdl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t           mem_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_r;
  logic [QAW-1:0] rd_r;
  logic [QAW:0]   cnt_r;

  assign full  = cnt_r == (QAW+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

### rtl/core/pgdl_back.sv
// Back end: delay memory, clearing pass, delayed-sample scaling and result register.
// Depends on pgdl_pkg. Pulls jobs from pgdl_queue.
module pgdl_back
  import pgdl_pkg::*;
#(
  parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  job_t                             head,
  output logic                             pop,
  input  logic [$clog2(DELAY_DEPTH)-1:0]   dly,
  output logic                             clr_busy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic signed [15:0]               wet_sample,
  output logic [1:0]                       nearest_sensor,
  output logic [15:0]                      applied_gain
);

  localparam int AW = $clog2(DELAY_DEPTH);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_WB   = 3'b100
  } bstate_t;

  bstate_t st_r, st_nxt;

  logic signed [15:0] mem [DELAY_DEPTH];
  logic signed [15:0] rdata_r;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [15:0] wdata;
  logic [AW-1:0]      raddr;

  logic               clr_busy_r;
  logic [AW-1:0]      clr_cnt_r;
  logic [AW-1:0]      wp_r;
  logic [AW-1:0]      rd_r;
  logic               same_r;
  logic [15:0]        gain_r;
  logic [1:0]         idx_r;
  logic signed [32:0] prod_r;
  logic signed [32:0] s15;
  logic signed [32:0] s16;
  logic [AW:0]        wrap_sum;
  logic               fire;

  logic               out_v_r;
  logic signed [15:0] wet_r;
  logic [1:0]         near_r;
  logic [15:0]        gout_r;

  assign clr_busy       = clr_busy_r;
  assign out_tvalid     = out_v_r;
  assign wet_sample     = wet_r;
  assign nearest_sensor = near_r;
  assign applied_gain   = gout_r;

  assign pop  = (st_r == B_IDLE) && !q_empty && !clr_busy_r;
  assign fire = (st_r == B_WB) && (!out_v_r || out_tready);

  always_comb begin
    wrap_sum = {1'b0, wp_r} + (AW+1)'(DELAY_DEPTH) - {1'b0, dly};
    raddr    = (wp_r >= dly) ? (wp_r - dly) : wrap_sum[AW-1:0];
    s15      = prod_r + 33'sd16384;
    s16      = prod_r + 33'sd32768;
  end

  always_comb begin
    we    = 1'b0;
    waddr = wp_r;
    wdata = head.dry;
    if (clr_busy_r) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else if (pop) begin
      we = 1'b1;
    end else if (fire && !same_r) begin
      we    = 1'b1;
      waddr = rd_r;
      wdata = s15[30:15];
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE: if (pop) st_nxt = B_MUL;
      B_MUL:  st_nxt = B_WB;
      B_WB:   if (fire) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= B_IDLE;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      wp_r       <= '0;
      out_v_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DELAY_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (pop) begin
        wp_r <= (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_r   <= raddr;
      same_r <= dly == '0;
      gain_r <= head.gain;
      idx_r  <= head.idx;
    end
    if (st_r == B_MUL) begin
      prod_r <= rdata_r * $signed({1'b0, gain_r});
    end
    if (fire) begin
      wet_r  <= s16[31:16];
      near_r <= idx_r;
      gout_r <= gain_r;
    end
  end

endmodule
